>>> hw/rtl/cgcs_pkg.sv
// Package for the cache group column splitter.
// Holds the shared widths, the reset budget and the arithmetic unit's request and response types.
// No dependencies.
package cgcs_pkg;

    localparam int unsigned MAX_WIDTH   = 64;
    localparam int unsigned WID_W       = 7;
    localparam int unsigned LEN_W       = 20;
    localparam int unsigned POS_W       = 20;
    localparam int unsigned BUD_W       = 24;
    localparam int unsigned OPD_W       = 25;
    localparam int unsigned RES_W       = OPD_W + 1;

    localparam logic [BUD_W-1:0] BUDGET_RESET = 24'd29491;

    // Operation codes of the shared add/compare unit.
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [OPD_W-1:0] a;
        logic [OPD_W-1:0] b;
        logic [OPD_W-1:0] c;
    } t_alu_req;

    typedef struct packed {
        logic [RES_W-1:0] res;
        logic             lt;
    } t_alu_rsp;

endpackage

>>> hw/rtl/cgcs_alu.sv
// Shared add/subtract and compare unit of the column splitter.
// Computes a +/- b and flags whether that result is below c (signed).
// Depends on cgcs_pkg.
module cgcs_alu (
    input  cgcs_pkg::t_alu_req i_req,
    output cgcs_pkg::t_alu_rsp o_rsp
);
    import cgcs_pkg::*;

    logic [RES_W-1:0] w_a;
    logic [RES_W-1:0] w_b;
    logic [RES_W-1:0] w_c;
    logic [RES_W-1:0] w_res;

    // Zero-extend the operands by one bit so the result carries a sign.
    assign w_a = {1'b0, i_req.a};
    assign w_b = {1'b0, i_req.b};
    assign w_c = {1'b0, i_req.c};

    always_comb begin
        case (i_req.op)
            ALU_ADD: w_res = w_a + w_b;
            ALU_SUB: w_res = w_a - w_b;
            default: w_res = w_a + w_b;
        endcase
    end

    assign o_rsp.res = w_res;
    assign o_rsp.lt  = $signed(w_res) < $signed(w_c);

endmodule

>>> hw/rtl/cgcs_out_reg.sv
// Output register of the column splitter's result channel.
// Holds one group transaction until the receiver takes it; depends on cgcs_pkg.
module cgcs_out_reg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [cgcs_pkg::POS_W-1:0] i_start,
    input  logic [cgcs_pkg::WID_W-1:0] i_len,
    input  logic                      i_last,
    output logic                      o_free,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [cgcs_pkg::POS_W-1:0] o_start,
    output logic [cgcs_pkg::WID_W-1:0] o_len,
    output logic                      o_last
);
    import cgcs_pkg::*;

    logic             r_valid;
    logic [POS_W-1:0] r_start;
    logic [WID_W-1:0] r_len;
    logic             r_last;

    // The register may be refilled when empty or when its transaction leaves now.
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload is loaded only together with a new transaction.
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_start <= i_start;
            r_len   <= i_len;
            r_last  <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_start = r_start;
    assign o_len   = r_len;
    assign o_last  = r_last;

endmodule

>>> hw/rtl/cache_group_column_splitter.sv
// Cache group column splitter: top level with the scan sequencer.
// Depends on cgcs_pkg, cgcs_alu and cgcs_out_reg.
//
// One supernode (first column length, width, last flag) is accepted at a time and cut into
// cache groups that are sent out in column order, the final one marked. The scan tests one
// column per cycle through a single shared adder/comparator, except while the result channel
// holds back a pending group, which stalls the scan. The final group becomes valid in the
// cycle the block is ready again; a width of zero produces no group and leaves the block idle.
// The input stall is high for the whole scan. The budget register is written through its own
// port, which is always ready; write it only while the block is idle.
module cache_group_column_splitter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cgcs_pkg::BUD_W-1:0] i_cfg_data,
    // Supernode input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [cgcs_pkg::LEN_W-1:0] i_first_col_len,
    input  logic [cgcs_pkg::WID_W-1:0] i_width,
    input  logic                       i_last_supernode,
    // Cache group output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [cgcs_pkg::POS_W-1:0] o_group_start,
    output logic [cgcs_pkg::WID_W-1:0] o_group_len,
    output logic                       o_last_group
);
    import cgcs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_SPLIT,
        ST_SCAN
    } t_state;

    t_state           r_state, n_state;
    logic [BUD_W-1:0] r_budget;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_len, n_len;
    logic [BUD_W-1:0] r_used, n_used;
    logic [WID_W-1:0] r_w, n_w;
    logic [WID_W-1:0] r_j, n_j;
    logic [WID_W-1:0] r_k, n_k;
    logic [WID_W-1:0] r_s, n_s;
    logic             r_last, n_last;

    t_alu_req         w_req;
    t_alu_rsp         w_rsp;
    logic             w_free;
    logic             w_emit;
    logic [WID_W-1:0] w_emit_off;
    logic [WID_W-1:0] w_emit_len;
    logic             w_emit_last;
    logic [LEN_W-1:0] w_len_dec;
    logic [LEN_W-1:0] w_s_full;
    logic [POS_W-1:0] w_pos_end;
    logic [LEN_W:0]   w_two_len;

    // Configuration port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= BUDGET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_budget <= i_cfg_data;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // Column lengths fall by one per column and stop at zero.
    assign w_len_dec = (r_len != '0) ? (r_len - LEN_W'(1)) : r_len;
    assign w_two_len = {r_len, 1'b0};
    assign w_s_full  = w_rsp.res[LEN_W:1];
    assign w_pos_end = r_last ? '0 : (r_pos + POS_W'(r_w));

    cgcs_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // Sequencer: drives the shared unit and decides each step and group emission.
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_len       = r_len;
        n_used      = r_used;
        n_w         = r_w;
        n_j         = r_j;
        n_k         = r_k;
        n_s         = r_s;
        n_last      = r_last;
        w_emit      = 1'b0;
        w_emit_off  = '0;
        w_emit_len  = '0;
        w_emit_last = 1'b0;
        w_req.op    = ALU_ADD;
        w_req.a     = OPD_W'(r_used);
        w_req.b     = OPD_W'(r_len);
        w_req.c     = OPD_W'(r_budget);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_len  = i_first_col_len;
                    n_last = i_last_supernode;
                    n_w    = (i_width > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : i_width;
                    if (i_width == '0) begin
                        // An empty supernode emits nothing; position stays unless last.
                        if (i_last_supernode) begin
                            n_pos = '0;
                        end
                    end else begin
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                // Test whether the first column alone overruns the budget.
                w_req.op = ALU_SUB;
                w_req.a  = OPD_W'(w_two_len);
                w_req.b  = OPD_W'(r_budget);
                w_req.c  = OPD_W'(1);
                if (!w_rsp.lt) begin
                    if (w_s_full >= LEN_W'(r_w)) begin
                        // The leading group covers the whole supernode.
                        w_emit      = 1'b1;
                        w_emit_off  = '0;
                        w_emit_len  = r_w;
                        w_emit_last = 1'b1;
                        if (w_free) begin
                            n_pos   = w_pos_end;
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_s     = w_s_full[WID_W-1:0];
                        n_state = ST_SPLIT;
                    end
                end else begin
                    n_used  = BUD_W'(w_two_len);
                    n_j     = '0;
                    n_k     = WID_W'(1);
                    n_len   = w_len_dec;
                    n_state = ST_SCAN;
                end
            end
            ST_SPLIT: begin
                // Split off the leading columns and retest the first column after them.
                w_req.op = ALU_SUB;
                w_req.a  = OPD_W'(r_len);
                w_req.b  = OPD_W'(r_s);
                w_req.c  = '0;
                w_emit      = (r_s != '0);
                w_emit_off  = '0;
                w_emit_len  = r_s;
                w_emit_last = 1'b0;
                if (!w_emit || w_free) begin
                    n_len   = w_rsp.res[LEN_W-1:0];
                    n_used  = BUD_W'({w_rsp.res[LEN_W-1:0], 1'b0});
                    n_j     = r_s;
                    n_k     = r_s;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_k == r_w) begin
                    // Close the open group as the supernode's final one.
                    w_emit      = 1'b1;
                    w_emit_off  = r_j;
                    w_emit_len  = r_w - r_j;
                    w_emit_last = 1'b1;
                    if (w_free) begin
                        n_pos   = w_pos_end;
                        n_state = ST_IDLE;
                    end
                end else if (w_rsp.lt) begin
                    // Column fits in the open group.
                    n_used = w_rsp.res[BUD_W-1:0];
                    n_len  = w_len_dec;
                    n_k    = r_k + WID_W'(1);
                end else begin
                    // Column starts a new group; the old one goes out if not empty.
                    w_emit      = (r_k > r_j);
                    w_emit_off  = r_j;
                    w_emit_len  = r_k - r_j;
                    w_emit_last = 1'b0;
                    if (!w_emit || w_free) begin
                        n_j    = r_k;
                        n_used = BUD_W'(w_two_len);
                        n_len  = w_len_dec;
                        n_k    = r_k + WID_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
        r_len  <= n_len;
        r_used <= n_used;
        r_w    <= n_w;
        r_j    <= n_j;
        r_k    <= n_k;
        r_s    <= n_s;
        r_last <= n_last;
    end

    cgcs_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_emit),
        .i_start (r_pos + POS_W'(w_emit_off)),
        .i_len   (w_emit_len),
        .i_last  (w_emit_last),
        .o_free  (w_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_start (o_group_start),
        .o_len   (o_group_len),
        .o_last  (o_last_group)
    );

`ifndef SYNTHESIS
    // Every emitted group holds at least one column.
    a_group_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_group_len != '0))
        else $error("empty cache group emitted");

    // The scan never runs past the supernode's last column.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_k <= r_w) && (r_j < r_w) && (r_j <= r_k)))
        else $error("scan index out of range");

    // A new supernode is taken only by leaving the idle state.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_width != '0)) |=> (r_state == ST_INIT))
        else $error("accepted supernode did not start a scan");

    // Returning to idle from a scan is always paired with a final group.
    a_final_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && (n_state == ST_IDLE)) |=> (o_out_valid && o_last_group))
        else $error("scan ended without final group");
`endif

endmodule

>>> test/tb_cache_group_column_splitter.sv
// Self-checking testbench for the cache group column splitter.
// Predicts the cache groups of every accepted supernode and compares each output transaction.
// Depends on cgcs_pkg and cache_group_column_splitter.
`timescale 1ns / 100ps

module tb_cache_group_column_splitter;

    import cgcs_pkg::*;

    // Cycles allowed for the scan of a widest supernode to retire after the last group.
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 22;
    localparam int STALL_RUN_MAX = 6;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [WID_W-1:0] ncols;
        logic             is_last;
    } cache_group_t;

    logic             i_clk            = 1'b0;
    logic             i_rst_n          = 1'b0;
    logic             i_cfg_valid      = 1'b0;
    logic [BUD_W-1:0] i_cfg_data       = '0;
    logic             i_in_valid       = 1'b0;
    logic [LEN_W-1:0] i_first_col_len  = '0;
    logic [WID_W-1:0] i_width          = '0;
    logic             i_last_supernode = 1'b0;
    logic             i_out_stall      = 1'b0;
    logic             o_cfg_ready;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [POS_W-1:0] o_group_start;
    logic [WID_W-1:0] o_group_len;
    logic             o_last_group;

    // Predictor copy of the block's column position and budget register.
    logic [POS_W-1:0] col_position = '0;
    logic [BUD_W-1:0] budget_cfg   = BUDGET_RESET;
    cache_group_t     pending_groups[$];

    int error_count     = 0;
    int stall_pct       = 0;
    int stall_left      = 0;
    int gap_max         = 0;
    int burst_left      = 0;

    always #5 i_clk = ~i_clk;

    cache_group_column_splitter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_first_col_len (i_first_col_len),
        .i_width         (i_width),
        .i_last_supernode(i_last_supernode),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_group_start   (o_group_start),
        .o_group_len     (o_group_len),
        .o_last_group    (o_last_group)
    );

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Cut one supernode into cache groups and queue them, then advance the column position.
    function automatic void predict_groups(input logic [LEN_W-1:0] first_len,
                                           input logic [WID_W-1:0] wid,
                                           input logic last_sn);
        longint unsigned cur_len;
        longint unsigned used;
        longint unsigned b;
        longint unsigned s;
        int unsigned     w;
        int unsigned     k;
        int unsigned     j;
        int unsigned     n;
        int unsigned     starts[MAX_WIDTH];
        int unsigned     lens[MAX_WIDTH];
        cache_group_t    grp;

        cur_len = first_len;
        b       = budget_cfg;
        w       = (wid > MAX_WIDTH) ? MAX_WIDTH : wid;
        n       = 0;
        j       = 0;
        k       = 0;
        used    = 0;

        if (w > 0) begin
            used = 2 * cur_len;
            if (used > b) begin
                // Oversized leading columns are split off as one group.
                s = (used - b) >> 1;
                if (s >= w) begin
                    k = w;
                end else begin
                    k       = s;
                    cur_len = cur_len - s;
                    used    = 2 * cur_len;
                end
                if (k > 0) begin
                    starts[n] = 0;
                    lens[n]   = k;
                    n++;
                end
                j = k;
            end else begin
                j = 0;
                k = 1;
                if (cur_len > 0) cur_len--;
            end

            // Scan one column at a time; a column that does not fit opens a new group.
            while (k < w) begin
                if (used + cur_len < b) begin
                    used = used + cur_len;
                end else begin
                    if (k > j) begin
                        starts[n] = j;
                        lens[n]   = k - j;
                        n++;
                    end
                    j    = k;
                    used = 2 * cur_len;
                end
                if (cur_len > 0) cur_len--;
                k++;
            end

            if (j < w) begin
                starts[n] = j;
                lens[n]   = w - j;
                n++;
            end
        end

        for (int i = 0; i < n; i++) begin
            grp.start   = POS_W'(col_position + starts[i]);
            grp.ncols   = WID_W'(lens[i]);
            grp.is_last = (i == n - 1);
            pending_groups.push_back(grp);
        end

        col_position = POS_W'(col_position + w);
        if (last_sn) col_position = '0;
    endfunction

    // Drive one supernode, hold it until accepted, then maybe pause between bursts.
    task automatic send_supernode(input logic [LEN_W-1:0] len, input logic [WID_W-1:0] wid,
                                  input logic last_sn);
        int gap;
        i_in_valid       <= 1'b1;
        i_first_col_len  <= len;
        i_width          <= wid;
        i_last_supernode <= last_sn;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_groups(len, wid, last_sn);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 8);
            if (gap_max > 0) begin
                gap = $urandom_range(1, gap_max);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    // Wait for every predicted group; optionally let the scan retire before a register write.
    task automatic wait_drained(input bit settle);
        while (pending_groups.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_budget(input logic [BUD_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        budget_cfg = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] random_len(input logic [BUD_W-1:0] b);
        longint unsigned v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = $urandom_range(0, 20'hFFFFF);
            2: v = $urandom_range(1, 64);
            3: begin
                // Near half the budget, where a leading group gets split off.
                v = b / 2 + $urandom_range(0, 140);
                if (v >= 40) v = v - 40;
            end
            default: v = b / $urandom_range(2, 64) + $urandom_range(0, 8);
        endcase
        if (v > 20'hFFFFF) v = $urandom_range(0, 20'hFFFFF);
        return v[LEN_W-1:0];
    endfunction

    function automatic logic [WID_W-1:0] random_width();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r <= 2) return WID_W'($urandom_range(MAX_WIDTH + 1, 127));
        if (r == 3) return WID_W'(MAX_WIDTH);
        return WID_W'($urandom_range(1, MAX_WIDTH));
    endfunction

    // Receiver stall pattern: random runs whose density each test chooses.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, STALL_RUN_MAX);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare every accepted output transaction with the oldest predicted group.
    always @(posedge i_clk) begin : check_groups
        cache_group_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_groups.size() == 0) begin
                report_mismatch($sformatf("unexpected group start %0d len %0d",
                                          o_group_start, o_group_len));
            end else begin
                want = pending_groups.pop_front();
                if (o_group_start !== want.start)
                    report_mismatch($sformatf("group_start got %0d want %0d",
                                              o_group_start, want.start));
                if (o_group_len !== want.ncols)
                    report_mismatch($sformatf("group_len got %0d want %0d",
                                              o_group_len, want.ncols));
                if (o_last_group !== want.is_last)
                    report_mismatch($sformatf("last_group got %0b want %0b",
                                              o_last_group, want.is_last));
            end
        end
    end

    // Reset budget: single columns, oversized splits, zero lengths and widths, saturation.
    task automatic test_reset_budget_items();
        gap_max   = 2;
        stall_pct = 25;
        send_supernode(20'd1, 7'd1, 1'b0);
        send_supernode(20'hFFFFF, 7'd64, 1'b0);
        send_supernode(20'd14760, 7'd64, 1'b0);
        send_supernode(20'd14746, 7'd10, 1'b0);
        send_supernode(20'd14745, 7'd3, 1'b0);
        send_supernode(20'd0, 7'd5, 1'b0);
        send_supernode(20'd500, 7'd64, 1'b0);
        send_supernode(20'd3000, 7'd40, 1'b0);
        send_supernode(20'd77, 7'd0, 1'b0);
        send_supernode(20'd2000, 7'd65, 1'b0);
        send_supernode(20'd2000, 7'd127, 1'b0);
        send_supernode(20'd1200, 7'd20, 1'b1);
        send_supernode(20'd900, 7'd33, 1'b0);
        stop_sending();
        wait_drained(1'b1);
    endtask

    // Budget at zero, at its maximum and at one.
    task automatic test_budget_extremes();
        write_budget('0);
        send_supernode(20'd1, 7'd64, 1'b0);
        send_supernode(20'd0, 7'd4, 1'b0);
        send_supernode(20'hFFFFF, 7'd12, 1'b1);
        stop_sending();
        wait_drained(1'b1);
        write_budget('1);
        send_supernode(20'hFFFFF, 7'd64, 1'b0);
        send_supernode(20'hFFFFF, 7'd127, 1'b0);
        send_supernode(20'd1, 7'd2, 1'b1);
        stop_sending();
        wait_drained(1'b1);
        write_budget(24'd1);
        send_supernode(20'd1, 7'd9, 1'b0);
        send_supernode(20'd0, 7'd9, 1'b1);
        stop_sending();
        wait_drained(1'b1);
    endtask

    // Random supernodes over several budgets, sender gaps and stall densities.
    task automatic test_random_phases();
        logic [BUD_W-1:0] budgets[6];
        int               stall_set[6] = '{0, 30, 60, 20, 80, 10};
        int               gap_set[6]   = '{0, 4, 8, 2, 6, 3};
        budgets[0] = BUDGET_RESET;
        budgets[1] = BUD_W'($urandom_range(0, 255));
        budgets[2] = BUD_W'($urandom);
        budgets[3] = '0;
        budgets[4] = '1;
        budgets[5] = BUD_W'($urandom_range(1000, 200000));
        for (int p = 0; p < 6; p++) begin
            write_budget(budgets[p]);
            stall_pct = stall_set[p];
            gap_max   = gap_set[p];
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Once, hold the sender back until every group has come out.
                if (p == 2 && i == PHASE_ITEMS / 2) begin
                    stop_sending();
                    @(posedge i_clk);
                    wait_drained(1'b0);
                end
                send_supernode(random_len(budgets[p]), random_width(),
                               $urandom_range(0, 9) == 0);
            end
            stop_sending();
            wait_drained(1'b1);
        end
    endtask

    // Return the column position to zero on a last supernode, then split the ones after it.
    task automatic test_position_restart();
        stall_pct = 30;
        gap_max   = 0;
        write_budget(BUDGET_RESET);
        send_supernode(20'd3000, 7'd64, 1'b0);
        send_supernode(20'd300, 7'd40, 1'b1);
        send_supernode(20'd3000, 7'd8, 1'b0);
        stop_sending();
        wait_drained(1'b1);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_budget_items();
        test_budget_extremes();
        test_random_phases();
        test_position_restart();
        if (error_count == 0) begin
            $display("tb_cache_group_column_splitter: clean");
        end else begin
            $display("tb_cache_group_column_splitter: errors");
        end
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial begin
        #10_000_000;
        $display("tb_cache_group_column_splitter: errors");
        $finish;
    end

endmodule
